>>> hdl/lst_pkg.sv
`default_nettype none
package lst_pkg;

    localparam logic [5:0] K_COMMENT   = 6'd0;
    localparam logic [5:0] K_STRING    = 6'd1;
    localparam logic [5:0] K_LPAREN    = 6'd2;
    localparam logic [5:0] K_RPAREN    = 6'd3;
    localparam logic [5:0] K_QUOTE     = 6'd4;
    localparam logic [5:0] K_BACKQUOTE = 6'd5;
    localparam logic [5:0] K_INTEGER   = 6'd6;
    localparam logic [5:0] K_FLOAT     = 6'd7;
    localparam logic [5:0] K_COMMA     = 6'd8;
    localparam logic [5:0] K_COMMA_AT  = 6'd9;
    localparam logic [5:0] K_COMMA_DOT = 6'd10;
    localparam logic [5:0] K_DOT       = 6'd11;
    localparam logic [5:0] K_SYMBOL    = 6'd12;
    localparam logic [5:0] K_WS        = 6'd13;
    localparam logic [5:0] K_NEWLINE   = 6'd14;
    localparam logic [5:0] K_EOF       = 6'd15;
    localparam logic [5:0] K_ERROR     = 6'd16;
    localparam logic [5:0] K_SH_CHAR     = 6'd17;
    localparam logic [5:0] K_SH_FUNC     = 6'd18;
    localparam logic [5:0] K_SH_UNINTERN = 6'd19;
    localparam logic [5:0] K_SH_EVAL     = 6'd20;
    localparam logic [5:0] K_SH_BIN      = 6'd21;
    localparam logic [5:0] K_SH_OCT      = 6'd22;
    localparam logic [5:0] K_SH_HEX      = 6'd23;
    localparam logic [5:0] K_SH_COMPLEX  = 6'd24;
    localparam logic [5:0] K_SH_STRUCT   = 6'd25;
    localparam logic [5:0] K_SH_PATH     = 6'd26;
    localparam logic [5:0] K_SH_RPAREN   = 6'd27;
    localparam logic [5:0] K_SH_VECTOR   = 6'd28;
    localparam logic [5:0] K_SH_BITVEC   = 6'd29;
    localparam logic [5:0] K_SH_RADIX    = 6'd30;
    localparam logic [5:0] K_SH_ARRAY    = 6'd31;
    localparam logic [5:0] K_SH_LABEL    = 6'd32;
    localparam logic [5:0] K_SH_REF      = 6'd33;
    localparam logic [5:0] K_SH_PLUS     = 6'd34;
    localparam logic [5:0] K_SH_MINUS    = 6'd35;
    localparam logic [5:0] K_LAST      = K_SH_MINUS;

    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_UNTERM_STR = 3'd1;
    localparam logic [2:0] E_INCOMPLETE = 3'd2;
    localparam logic [2:0] E_BAD_MACRO  = 3'd3;

    localparam logic [7:0] CH_SHARP  = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] start_res;
        logic [20:0] length;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [2:0]  err_code;
    } tok_t;

    typedef struct packed {
        logic [2:0]             cnt;
        tok_t [MAX_RES-1:0]     tok;
    } bundle_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return c == CH_SEMI || c == CH_SQUOTE || c == CH_LPAREN || c == CH_RPAREN
            || c == CH_COMMA || c == CH_DQUOTE;
    endfunction

    // {hit, kind}
    function automatic logic [6:0] sharp_direct(input logic [7:0] c);
        logic [6:0] r;
        case (c)
            CH_BSLASH: r = {1'b1, K_SH_CHAR};
            CH_SQUOTE: r = {1'b1, K_SH_FUNC};
            8'h3A:     r = {1'b1, K_SH_UNINTERN};
            CH_DOT:    r = {1'b1, K_SH_EVAL};
            8'h42:     r = {1'b1, K_SH_BIN};
            8'h4F:     r = {1'b1, K_SH_OCT};
            8'h58:     r = {1'b1, K_SH_HEX};
            8'h43:     r = {1'b1, K_SH_COMPLEX};
            8'h53:     r = {1'b1, K_SH_STRUCT};
            8'h50:     r = {1'b1, K_SH_PATH};
            CH_RPAREN: r = {1'b1, K_SH_RPAREN};
            default:   r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] sharp_with_arg(input logic [7:0] c);
        logic [6:0] r;
        case (c)
            CH_LPAREN: r = {1'b1, K_SH_VECTOR};
            8'h2A:     r = {1'b1, K_SH_BITVEC};
            8'h52:     r = {1'b1, K_SH_RADIX};
            8'h41:     r = {1'b1, K_SH_ARRAY};
            8'h3D:     r = {1'b1, K_SH_LABEL};
            CH_SHARP:  r = {1'b1, K_SH_REF};
            8'h2B:     r = {1'b1, K_SH_PLUS};
            CH_MINUS:  r = {1'b1, K_SH_MINUS};
            default:   r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic bundle_t push_tok(input bundle_t b, input tok_t t);
        bundle_t r;
        r = b;
        if (b.cnt < 3'(MAX_RES))
        begin
            r.tok[b.cnt[1:0]] = t;
            r.cnt = b.cnt + 3'd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/lst_front.sv
`default_nettype none
module lst_front
    import lst_pkg::*;
#(
    parameter longint unsigned MAX_SOURCE_BYTES = 64'd1048576,
    parameter longint unsigned MAX_LINES        = 64'd65536
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    take,
    input  wire logic [7:0] ch,
    input  wire logic    last,
    output bundle_t      bundle,
    output logic         push
);

    localparam int PW = $clog2(MAX_SOURCE_BYTES + 64'd1);
    localparam int LW = $clog2(MAX_LINES);

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_STRING, M_WS, M_SYM, M_NEG, M_INT, M_INTDOT,
        M_FLOAT, M_COMMA, M_DOT, M_SHARP, M_SHARPNUM, M_SKIP
    } mode_t;

    mode_t          mode_reg, mode_next;
    logic [PW-1:0]  ts_reg, ts_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [LW-1:0]  line_reg, line_next;
    logic [15:0]    col_reg, col_next;
    logic [7:0]     prev_reg, prev_next;
    logic           held_reg, held_next;

    function automatic logic [PW-1:0] inc_pos(input logic [PW-1:0] p);
        return (64'(p) < MAX_SOURCE_BYTES) ? PW'(p + 1'b1) : p;
    endfunction

    function automatic logic [15:0] inc_col(input logic [15:0] c);
        return (c != 16'hFFFF) ? c + 16'd1 : c;
    endfunction

    function automatic logic [LW-1:0] inc_line(input logic [LW-1:0] l);
        return (64'(l) < MAX_LINES - 64'd1) ? LW'(l + 1'b1) : l;
    endfunction

    function automatic tok_t mk_tok(input logic [5:0] k, input logic [PW-1:0] s,
                                    input logic [PW-1:0] e, input logic [2:0] er,
                                    input logic [LW-1:0] l, input logic [15:0] c);
        logic [63:0] sc;
        logic [63:0] d;
        logic [63:0] lw;
        tok_t t;
        sc = 64'(s);
        if (sc > MAX_SOURCE_BYTES - 64'd1)
            sc = MAX_SOURCE_BYTES - 64'd1;
        d = 64'(e) - 64'(s);
        lw = 64'(l);
        t.kind = k;
        t.start_res = sc[19:0];
        t.length = d[20:0];
        t.line_no = lw[15:0];
        t.col_no = c;
        t.err_code = er;
        return t;
    endfunction

    always_comb
    begin
        bundle_t       b;
        mode_t         md;
        logic [PW-1:0] ts, pos, cur;
        logic [LW-1:0] ln;
        logic [15:0]   cl;
        logic          hd, again, from_ws, symb, brk;
        logic [6:0]    kd;
        b = '0;
        md = mode_reg;
        ts = ts_reg;
        pos = pos_reg;
        cur = pos_reg;
        ln = line_reg;
        cl = col_reg;
        hd = held_reg;
        again = 1'b0;
        from_ws = 1'b0;
        symb = !is_ws(ch) && (prev_reg == CH_BSLASH || !is_special(ch));
        kd = 7'd0;
        brk = is_ws(ch) || ch == CH_LPAREN || ch == CH_RPAREN;

        if (hd)
        begin
            hd = 1'b0;
            if (ch == CH_LF)
            begin
                pos = inc_pos(pos); cl = inc_col(cl);
                b = push_tok(b, mk_tok(K_NEWLINE, ts, pos, E_NONE, ln, cl));
                cl = 16'd0; ln = inc_line(ln);
                md = M_IDLE;
            end
            else
            begin
                b = push_tok(b, mk_tok(K_NEWLINE, ts, pos, E_NONE, ln, cl));
                cl = 16'd0; ln = inc_line(ln);
                md = M_IDLE;
                again = 1'b1;
            end
        end
        else
        begin
            case (md)
                M_COMMENT:
                    if (ch == CH_LF || ch == CH_CR)
                    begin
                        b = push_tok(b, mk_tok(K_COMMENT, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                    end
                    else
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl);
                    end
                M_STRING:
                begin
                    pos = inc_pos(pos); cl = inc_col(cl);
                    if (ch == CH_DQUOTE && prev_reg != CH_BSLASH)
                    begin
                        b = push_tok(b, mk_tok(K_STRING, ts, pos, E_NONE, ln, cl));
                        md = M_IDLE;
                    end
                end
                M_WS:
                    if (ch == CH_SPACE || ch == CH_TAB)
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl);
                    end
                    else
                    begin
                        b = push_tok(b, mk_tok(K_WS, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                        from_ws = 1'b1;
                    end
                M_NEG, M_SYM:
                    if (md == M_NEG && is_digit(ch))
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_INT;
                    end
                    else
                    begin
                        md = M_SYM;
                        if (symb)
                        begin
                            pos = inc_pos(pos); cl = inc_col(cl);
                        end
                        else
                        begin
                            b = push_tok(b, mk_tok(K_SYMBOL, ts, cur, E_NONE, ln, cl));
                            again = 1'b1;
                        end
                    end
                M_INT:
                    if (is_digit(ch))
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl);
                    end
                    else if (ch == CH_DOT)
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_INTDOT;
                    end
                    else if (symb)
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_SYM;
                    end
                    else
                    begin
                        b = push_tok(b, mk_tok(K_INTEGER, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                    end
                M_INTDOT:
                    if (is_digit(ch))
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_FLOAT;
                    end
                    else if (is_ws(ch))
                    begin
                        b = push_tok(b, mk_tok(K_INTEGER, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                    end
                    else if (symb)
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_SYM;
                    end
                    else
                    begin
                        b = push_tok(b, mk_tok(K_SYMBOL, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                    end
                M_FLOAT:
                    if (is_digit(ch))
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl);
                    end
                    else if (ch != CH_DOT && symb)
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_SYM;
                    end
                    else
                    begin
                        b = push_tok(b, mk_tok(K_FLOAT, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                    end
                M_COMMA:
                    if (ch == CH_AT || ch == CH_DOT)
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl);
                        b = push_tok(b, mk_tok((ch == CH_AT) ? K_COMMA_AT : K_COMMA_DOT,
                                               ts, pos, E_NONE, ln, cl));
                        md = M_IDLE;
                    end
                    else
                    begin
                        b = push_tok(b, mk_tok(K_COMMA, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                    end
                M_DOT:
                    if (symb)
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_SYM;
                    end
                    else
                    begin
                        b = push_tok(b, mk_tok(K_DOT, ts, cur, E_NONE, ln, cl));
                        again = 1'b1;
                    end
                M_SHARP, M_SHARPNUM:
                begin
                    kd = (md == M_SHARP) ? sharp_direct(ch) : 7'd0;
                    if (!kd[6] && is_digit(ch))
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl); md = M_SHARPNUM;
                    end
                    else
                    begin
                        if (!kd[6])
                            kd = sharp_with_arg(ch);
                        if (kd[6])
                        begin
                            pos = inc_pos(pos); cl = inc_col(cl);
                            b = push_tok(b, mk_tok(kd[5:0], ts, pos, E_NONE, ln, cl));
                            md = M_IDLE;
                        end
                        else if (brk)
                        begin
                            b = push_tok(b, mk_tok(K_ERROR, ts, cur, E_BAD_MACRO, ln, cl));
                            again = 1'b1;
                        end
                        else
                        begin
                            pos = inc_pos(pos); cl = inc_col(cl);
                            b = push_tok(b, mk_tok(K_ERROR, ts, pos, E_BAD_MACRO, ln, cl));
                            md = M_SKIP;
                        end
                    end
                end
                M_SKIP:
                    if (brk)
                        again = 1'b1;
                    else
                    begin
                        pos = inc_pos(pos); cl = inc_col(cl);
                    end
                default:
                    again = 1'b1;
            endcase
        end

        if (again)
        begin
            ts = pos;
            md = M_IDLE;
            case (ch)
                CH_SEMI:   begin pos = inc_pos(pos); cl = inc_col(cl); md = M_COMMENT; end
                CH_DQUOTE: begin pos = inc_pos(pos); cl = inc_col(cl); md = M_STRING; end
                CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_BTICK:
                begin
                    pos = inc_pos(pos); cl = inc_col(cl);
                    b = push_tok(b, mk_tok((ch == CH_LPAREN) ? K_LPAREN :
                                           (ch == CH_RPAREN) ? K_RPAREN :
                                           (ch == CH_SQUOTE) ? K_QUOTE : K_BACKQUOTE,
                                           ts, pos, E_NONE, ln, cl));
                end
                CH_MINUS:  begin pos = inc_pos(pos); cl = inc_col(cl); md = M_NEG; end
                CH_COMMA:  begin pos = inc_pos(pos); cl = inc_col(cl); md = M_COMMA; end
                CH_SHARP:  begin pos = inc_pos(pos); cl = inc_col(cl); md = M_SHARP; end
                CH_DOT:    begin pos = inc_pos(pos); cl = inc_col(cl); md = M_DOT; end
                CH_SPACE, CH_TAB:
                begin
                    pos = inc_pos(pos); cl = inc_col(cl); md = M_WS;
                end
                CH_LF, CH_CR:
                begin
                    if (!from_ws)
                        b = push_tok(b, mk_tok(K_WS, pos, pos, E_NONE, ln, cl));
                    pos = inc_pos(pos); cl = inc_col(cl);
                    if (ch == CH_LF)
                    begin
                        b = push_tok(b, mk_tok(K_NEWLINE, ts, pos, E_NONE, ln, cl));
                        cl = 16'd0; ln = inc_line(ln);
                    end
                    else
                        hd = 1'b1;
                end
                default:
                begin
                    pos = inc_pos(pos); cl = inc_col(cl);
                    md = (is_digit(ch) && prev_reg != CH_BSLASH) ? M_INT : M_SYM;
                end
            endcase
        end

        prev_next = ch;

        if (last)
        begin
            if (hd)
            begin
                b = push_tok(b, mk_tok(K_NEWLINE, ts, pos, E_NONE, ln, cl));
                cl = 16'd0; ln = inc_line(ln);
            end
            case (md)
                M_COMMENT: b = push_tok(b, mk_tok(K_COMMENT, ts, pos, E_NONE, ln, cl));
                M_STRING:  b = push_tok(b, mk_tok(K_ERROR, ts, pos, E_UNTERM_STR, ln, cl));
                M_WS:      b = push_tok(b, mk_tok(K_WS, ts, pos, E_NONE, ln, cl));
                M_SYM, M_NEG:
                    b = push_tok(b, mk_tok(K_SYMBOL, ts, pos, E_NONE, ln, cl));
                M_INT, M_INTDOT:
                    b = push_tok(b, mk_tok(K_INTEGER, ts, pos, E_NONE, ln, cl));
                M_FLOAT:   b = push_tok(b, mk_tok(K_FLOAT, ts, pos, E_NONE, ln, cl));
                M_COMMA:   b = push_tok(b, mk_tok(K_COMMA, ts, pos, E_NONE, ln, cl));
                M_DOT:     b = push_tok(b, mk_tok(K_DOT, ts, pos, E_NONE, ln, cl));
                M_SHARP, M_SHARPNUM:
                    b = push_tok(b, mk_tok(K_ERROR, ts, pos, E_INCOMPLETE, ln, cl));
                default: ;
            endcase
            b = push_tok(b, mk_tok(K_EOF, pos, pos, E_NONE, ln, cl));
            md = M_IDLE;
            ts = '0;
            pos = '0;
            ln = '0;
            cl = 16'd0;
            hd = 1'b0;
            prev_next = 8'd0;
        end

        mode_next = md;
        ts_next = ts;
        pos_next = pos;
        line_next = ln;
        col_next = cl;
        held_next = hd;
        bundle = b;
        push = take && (b.cnt != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            ts_reg <= '0;
            pos_reg <= '0;
            line_reg <= '0;
            col_reg <= 16'd0;
            prev_reg <= 8'd0;
            held_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            ts_reg <= ts_next;
            pos_reg <= pos_next;
            line_reg <= line_next;
            col_reg <= col_next;
            prev_reg <= prev_next;
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/lst_fifo.sv
`default_nettype none
module lst_fifo
    import lst_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t wr_data,
    input  wire logic    pop,
    output bundle_t      rd_data,
    output logic         full,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bundle_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    assign full = (cnt_reg == (AW + 1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= wrap(wr_reg);
            if (pop && !empty)
                rd_reg <= wrap(rd_reg);
            if ((push && !full) && !(pop && !empty))
                cnt_reg <= cnt_reg + 1'b1;
            else if (!(push && !full) && (pop && !empty))
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

>>> hdl/lst_back.sv
`default_nettype none
module lst_back
    import lst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire bundle_t head,
    input  wire logic    empty,
    output logic         pop,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [79:0]  m_tdata,
    output logic [5:0]   m_tuser,
    output logic         m_tlast
);

    logic [1:0] idx_reg;
    logic       load;
    logic       fin;
    tok_t       t;

    assign load = !empty && (!m_tvalid || m_tready);
    assign t = head.tok[idx_reg];
    assign fin = ({1'b0, idx_reg} == head.cnt - 3'd1);
    assign pop = load && fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                m_tvalid <= 1'b1;
                idx_reg <= fin ? 2'd0 : idx_reg + 2'd1;
            end
            else if (m_tready)
                m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata <= {4'd0, t.err_code, t.col_no, t.line_no, t.length, t.start_res};
            m_tuser <= t.kind;
            m_tlast <= fin;
        end
    end

endmodule
`default_nettype wire

>>> hdl/lisp_source_tokenizer.sv
// Path: a byte's tokens are queued as it is accepted, then registered onto the output.
// Throughput: one byte per cycle while m_tready is high and each byte closes at most one
// token; tokens leave at one per cycle while m_tready is high, set by the serializer,
// and a byte may close up to four. A two-bundle queue sits between scanner and serializer.
// Reset: rst_n asynchronous, clears scanner state, queue and output valid.
`default_nettype none
module lisp_source_tokenizer
    import lst_pkg::*;
#(
    parameter longint unsigned MAX_SOURCE_BYTES = 64'd1048576,
    parameter longint unsigned MAX_LINES        = 64'd65536
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // start_res, length, line_no, col_no, err_code, pad
    output logic [5:0]       m_tuser,   // kind
    output logic             m_tlast
);

    bundle_t fr_bundle, hd_bundle;
    logic    fr_push, q_full, q_empty, bk_pop, take;

    assign s_tready = !q_full;
    assign take = s_tvalid && s_tready;

    lst_front #(
        .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
        .MAX_LINES(MAX_LINES)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .ch(s_tdata), .last(s_tlast),
        .bundle(fr_bundle), .push(fr_push)
    );

    lst_fifo #(.DEPTH(2)) u_fifo (
        .clk(clk), .rst_n(rst_n), .push(fr_push), .wr_data(fr_bundle),
        .pop(bk_pop), .rd_data(hd_bundle), .full(q_full), .empty(q_empty)
    );

    lst_back u_back (
        .clk(clk), .rst_n(rst_n), .head(hd_bundle), .empty(q_empty), .pop(bk_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule
`default_nettype wire

>>> hdl/lst_checker.sv
`default_nettype none
module lst_checker
    import lst_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic [5:0]  m_tuser,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= K_LAST)
        else $error("kind out of range");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != K_ERROR |-> m_tdata[75:73] == E_NONE)
        else $error("error code on non-error token");

    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == K_EOF |-> m_tlast && m_tdata[40:20] == 21'd0)
        else $error("eof not final or nonzero length");

endmodule

bind lisp_source_tokenizer lst_checker u_lst_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
